@@ src/tsf_pkg.sv @@
// Shared types for the triangle scanline fill block.
// Mode and job codes, and the command/status structs between controller and datapath.
// No dependencies.
package tsf_pkg;

  localparam int COORD_BITS_DEF = 12;

  // Input item mode codes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Which edge evaluation the shared multiply/divide unit is running.
  typedef enum logic [1:0] {
    JOB_SPLIT = 2'd0,
    JOB_LEFT  = 2'd1,
    JOB_RIGHT = 2'd2
  } job_t;

  typedef struct packed {
    logic busy;
    logic load_chk;
    logic mul;
    logic prep;
    logic div;
    logic fin;
    job_t job;
  } cmd_t;

  typedef struct packed {
    logic flat;
    logic need_split;
    logic step_setup;
  } stat_t;

endpackage

@@ src/tsf_ctrl.sv @@
// Controller for the triangle scanline fill block.
// Sequences load checks and edge jobs through the datapath. Uses tsf_pkg.
module tsf_ctrl #(
  parameter int COORD_BITS = tsf_pkg::COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic           mode_load,
  input  tsf_pkg::stat_t st,
  output tsf_pkg::cmd_t  cmd
);

  localparam int PROD_BITS = 2 * (COORD_BITS + 1);
  localparam int CNT_BITS  = $clog2(PROD_BITS);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_LOADCHK = 6'b000010,
    S_MUL     = 6'b000100,
    S_PREP    = 6'b001000,
    S_DIV     = 6'b010000,
    S_FIN     = 6'b100000
  } state_t;

  state_t            state, state_next;
  tsf_pkg::job_t     job, job_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    job_next   = job;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode_load) begin
            state_next = S_LOADCHK;
          end else if (st.step_setup) begin
            job_next   = tsf_pkg::JOB_LEFT;
            state_next = S_MUL;
          end
        end
      end
      S_LOADCHK: begin
        if (st.flat) begin
          state_next = S_IDLE;
        end else if (st.need_split) begin
          job_next   = tsf_pkg::JOB_SPLIT;
          state_next = S_MUL;
        end else begin
          job_next   = tsf_pkg::JOB_LEFT;
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_PREP;
      S_PREP: begin
        cnt_next   = CNT_BITS'(PROD_BITS - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        if (cnt == '0) begin
          state_next = S_FIN;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_FIN: begin
        unique case (job)
          tsf_pkg::JOB_SPLIT: begin
            job_next   = tsf_pkg::JOB_LEFT;
            state_next = S_MUL;
          end
          tsf_pkg::JOB_LEFT: begin
            job_next   = tsf_pkg::JOB_RIGHT;
            state_next = S_MUL;
          end
          default: state_next = S_IDLE;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job   <= tsf_pkg::JOB_SPLIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      job   <= job_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    cmd.busy     = (state != S_IDLE);
    cmd.load_chk = (state == S_LOADCHK);
    cmd.mul      = (state == S_MUL);
    cmd.prep     = (state == S_PREP);
    cmd.div      = (state == S_DIV);
    cmd.fin      = (state == S_FIN);
    cmd.job      = job;
  end

endmodule

@@ src/tsf_dp.sv @@
// Datapath for the triangle scanline fill block: vertex sort, span stepping,
// shared multiply and restoring divider for edge x, result registers. Uses tsf_pkg.
module tsf_dp #(
  parameter int COORD_BITS = tsf_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by_coord,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic [23:0]                  fill_color,
  input  tsf_pkg::cmd_t                cmd,
  output tsf_pkg::stat_t               st,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [23:0]                  pixel_color,
  output logic                         pixel_valid,
  output logic                         last_pixel
);

  localparam int CB = COORD_BITS;
  localparam int D1 = COORD_BITS + 1;
  localparam int PW = 2 * D1;

  logic signed [CB-1:0] sx [3];
  logic signed [CB-1:0] sy [3];
  logic signed [CB-1:0] split_x, row_y, span_x, span_end;
  logic                 half_phase, active;
  logic [23:0]          held_color;

  // divider state
  logic signed [PW-1:0] prod;
  logic signed [D1-1:0] den;
  logic signed [CB-1:0] xa_r;
  logic [PW-1:0]        quo;
  logic [D1-1:0]        rem, dmag;
  logic                 neg, dzero;

  // sort network on the incoming vertices
  logic signed [CB-1:0] lx [3];
  logic signed [CB-1:0] ly [3];
  always_comb begin
    logic signed [CB-1:0] tx, ty;
    tx = '0;
    ty = '0;
    lx[0] = ax; ly[0] = ay;
    lx[1] = bx; ly[1] = by_coord;
    lx[2] = cx; ly[2] = cy;
    if (ly[0] > ly[2]) begin
      tx = lx[0]; ty = ly[0]; lx[0] = lx[2]; ly[0] = ly[2]; lx[2] = tx; ly[2] = ty;
    end
    if (ly[0] > ly[1]) begin
      tx = lx[0]; ty = ly[0]; lx[0] = lx[1]; ly[0] = ly[1]; lx[1] = tx; ly[1] = ty;
    end
    if (ly[1] > ly[2]) begin
      tx = lx[1]; ty = ly[1]; lx[1] = lx[2]; ly[1] = ly[2]; lx[2] = tx; ly[2] = ty;
    end
  end

  // advance after emitting the current pixel
  logic signed [CB-1:0] span_x_step, row_step;
  logic                 phase_step, act_step, setup_step;
  always_comb begin
    span_x_step = span_x;
    row_step    = row_y;
    phase_step  = half_phase;
    act_step    = 1'b1;
    setup_step  = 1'b0;
    if (span_x != span_end) begin
      span_x_step = (span_x < span_end) ? span_x + 1'b1 : span_x - 1'b1;
    end else if (!half_phase) begin
      if (row_y < sy[1]) begin
        row_step   = row_y + 1'b1;
        setup_step = 1'b1;
      end else if (sy[1] < sy[2]) begin
        phase_step = 1'b1;
        row_step   = sy[1];
        setup_step = 1'b1;
      end else begin
        act_step = 1'b0;
      end
    end else begin
      if (row_y < sy[2]) begin
        row_step   = row_y + 1'b1;
        setup_step = 1'b1;
      end else begin
        act_step = 1'b0;
      end
    end
  end

  always_comb begin
    st.flat       = (sy[0] == sy[1]) && (sy[1] == sy[2]);
    st.need_split = (sy[0] != sy[1]) && (sy[1] != sy[2]);
    st.step_setup = (mode == tsf_pkg::MODE_STEP) && active && setup_step;
  end

  // edge operands: xa, ya, xb, yb, y
  logic signed [CB-1:0] op_xa, op_ya, op_xb, op_yb, op_y;
  always_comb begin
    unique case (cmd.job)
      tsf_pkg::JOB_SPLIT: begin
        op_xa = sx[2]; op_ya = sy[2]; op_xb = sx[0]; op_yb = sy[0]; op_y = sy[1];
      end
      tsf_pkg::JOB_LEFT: begin
        op_xa = half_phase ? sx[2] : sx[0];
        op_ya = half_phase ? sy[2] : sy[0];
        op_xb = sx[1]; op_yb = sy[1]; op_y = row_y;
      end
      default: begin
        op_xa = half_phase ? sx[2] : sx[0];
        op_ya = half_phase ? sy[2] : sy[0];
        op_xb = split_x; op_yb = sy[1]; op_y = row_y;
      end
    endcase
  end

  logic signed [D1-1:0] dx, dyv, dd;
  assign dx  = {op_xb[CB-1], op_xb} - {op_xa[CB-1], op_xa};
  assign dyv = {op_y[CB-1], op_y} - {op_ya[CB-1], op_ya};
  assign dd  = {op_yb[CB-1], op_yb} - {op_ya[CB-1], op_ya};

  // one restoring divide step
  logic [D1:0] shifted, trial;
  assign shifted = {rem, quo[PW-1]};
  assign trial   = shifted - {1'b0, dmag};

  logic [PW-1:0]        qs;
  logic signed [CB-1:0] res;
  assign qs  = neg ? -quo : quo;
  assign res = dzero ? xa_r : xa_r + $signed(qs[CB-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sx[i] <= '0;
        sy[i] <= '0;
      end
      split_x     <= '0;
      row_y       <= '0;
      span_x      <= '0;
      span_end    <= '0;
      half_phase  <= 1'b0;
      active      <= 1'b0;
      held_color  <= '0;
      pixel_x     <= '0;
      pixel_y     <= '0;
      pixel_color <= '0;
      pixel_valid <= 1'b0;
      last_pixel  <= 1'b0;
    end else begin
      if (accept) begin
        pixel_x     <= '0;
        pixel_y     <= '0;
        pixel_color <= '0;
        pixel_valid <= 1'b0;
        last_pixel  <= 1'b0;
        if (mode == tsf_pkg::MODE_LOAD) begin
          for (int i = 0; i < 3; i++) begin
            sx[i] <= lx[i];
            sy[i] <= ly[i];
          end
          held_color <= fill_color;
          active     <= 1'b0;
        end else if (active) begin
          pixel_x     <= span_x;
          pixel_y     <= row_y;
          pixel_color <= held_color;
          pixel_valid <= 1'b1;
          last_pixel  <= !act_step;
          span_x      <= span_x_step;
          row_y       <= row_step;
          half_phase  <= phase_step;
          active      <= act_step;
        end
      end
      if (cmd.load_chk && !st.flat) begin
        row_y <= sy[0];
        if (sy[0] == sy[1]) begin
          split_x    <= sx[0];
          half_phase <= 1'b1;
        end else if (sy[1] == sy[2]) begin
          split_x    <= sx[2];
          half_phase <= 1'b0;
        end else begin
          half_phase <= 1'b0;
        end
      end
      if (cmd.fin) begin
        unique case (cmd.job)
          tsf_pkg::JOB_SPLIT: begin
            if (sx[1] > res) begin
              sx[1]   <= res;
              split_x <= sx[1];
            end else begin
              split_x <= res;
            end
          end
          tsf_pkg::JOB_LEFT: span_x <= res;
          default: begin
            span_end <= res;
            active   <= 1'b1;
          end
        endcase
      end
    end
  end

  // multiply/divide registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PW'(dx) * PW'(dyv);
      den  <= dd;
      xa_r <= op_xa;
    end
    if (cmd.prep) begin
      quo   <= prod[PW-1] ? -prod : prod;
      rem   <= '0;
      dmag  <= den[D1-1] ? -den : den;
      neg   <= prod[PW-1] ^ den[D1-1];
      dzero <= (den == '0);
    end
    if (cmd.div) begin
      if (!trial[D1]) begin
        rem <= trial[D1-1:0];
        quo <= {quo[PW-2:0], 1'b1};
      end else begin
        rem <= shifted[D1-1:0];
        quo <= {quo[PW-2:0], 1'b0};
      end
    end
  end

endmodule

@@ src/triangle_scanline_fill_top.sv @@
// Top level of the triangle scanline fill block.
// Instantiates tsf_ctrl and tsf_dp; uses tsf_pkg.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------
//   in      | in_valid  | in_stall  | mode, ax, ay, bx, by_coord, cx, cy,
//           |           |           | fill_color
//   out     | out_valid | out_stall | pixel_x, pixel_y, pixel_color,
//           |           |           | pixel_valid, last_pixel
//
// Every accepted item gives one result item, registered the edge it is taken.
// A pixel step inside a span runs no edge job. A step that ends a row and
// starts the next, and a load, runs edge jobs on one shared multiply plus
// restoring divider: two jobs per row, three for a load that needs the split
// point and two for another load that is not flat. Every load first checks
// the sorted vertices; a flat triangle then runs no job.
// Synchronous active-high reset idles the block, zeroing all but the divider.
// in_stall is high while a load check or job runs or an untaken item waits.
module triangle_scanline_fill_top #(
  parameter int COORD_BITS = tsf_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by_coord,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic [23:0]                  fill_color,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic [23:0]                  pixel_color,
  output logic                         pixel_valid,
  output logic                         last_pixel
);

  tsf_pkg::cmd_t  cmd;
  tsf_pkg::stat_t st;
  logic           accept;

  // take a new item only when idle and the result register is free or draining
  assign in_stall = cmd.busy || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  tsf_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode_load (mode == tsf_pkg::MODE_LOAD),
    .st        (st),
    .cmd       (cmd)
  );

  tsf_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .mode        (mode),
    .ax          (ax),
    .ay          (ay),
    .bx          (bx),
    .by_coord    (by_coord),
    .cx          (cx),
    .cy          (cy),
    .fill_color  (fill_color),
    .cmd         (cmd),
    .st          (st),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .pixel_valid (pixel_valid),
    .last_pixel  (last_pixel)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for triangle_scanline_fill_top: directed and random triangles.
// Predicts each pixel with an in-bench rasterizer; depends on tsf_pkg and the RTL.
module tb;

  localparam int W = tsf_pkg::COORD_BITS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = tsf_pkg::MODE_STEP;
  logic signed [W-1:0] ax = '0, ay = '0, bx = '0, by_coord = '0, cx = '0, cy = '0;
  logic [23:0] fill_color = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [W-1:0] pixel_x, pixel_y;
  logic [23:0] pixel_color;
  logic pixel_valid, last_pixel;

  triangle_scanline_fill_top #(.COORD_BITS(W)) i_dut (.*);

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [23:0]  c;
    logic         v;
    logic         l;
  } pixel_t;

  pixel_t pending_pixels[$];
  int errors = 0;
  int idle_pct = 0;   // sender gap odds, percent per cycle
  int stall_pct = 0;  // receiver stall odds, percent per cycle

  // Rasterizer state: sorted vertices, split x, current half/row/span.
  int  vx[3], vy[3];
  int  split_x, row, span_x, span_end;
  bit  top_half, drawing;
  logic [23:0] tri_color;

  // Truncating edge interpolation; a zero-height edge returns its start x.
  function automatic int edge_at(int xa, int ya, int xb, int yb, int y);
    longint d;
    d = longint'(yb) - ya;
    if (d == 0) return xa;
    return int'((longint'(xb - xa) * longint'(y - ya)) / d + xa);
  endfunction

  function automatic void start_row();
    int e;
    e = top_half ? 2 : 0;
    span_x   = edge_at(vx[e], vy[e], vx[1], vy[1], row);
    span_end = edge_at(vx[e], vy[e], split_x, vy[1], row);
  endfunction

  function automatic void swap_vtx(int a, int b);
    int t;
    t = vx[a]; vx[a] = vx[b]; vx[b] = t;
    t = vy[a]; vy[a] = vy[b]; vy[b] = t;
  endfunction

  // Advance the rasterizer by one accepted item and return its result.
  function automatic pixel_t raster_next(bit m, int x0, int y0, int x1, int y1,
                                         int x2, int y2, logic [23:0] col);
    pixel_t p;
    int t;
    p = '{default: '0};
    if (m == tsf_pkg::MODE_LOAD) begin
      vx[0] = x0; vy[0] = y0; vx[1] = x1; vy[1] = y1; vx[2] = x2; vy[2] = y2;
      tri_color = col;
      if (vy[0] > vy[2]) swap_vtx(0, 2);
      if (vy[0] > vy[1]) swap_vtx(0, 1);
      if (vy[1] > vy[2]) swap_vtx(1, 2);
      drawing = 1'b0;
      if (vy[0] == vy[1] && vy[1] == vy[2]) return p;
      if (vy[0] == vy[1]) begin
        split_x = vx[0]; top_half = 1'b1;
      end else if (vy[1] == vy[2]) begin
        split_x = vx[2]; top_half = 1'b0;
      end else begin
        split_x = edge_at(vx[2], vy[2], vx[0], vy[0], vy[1]);
        if (vx[1] > split_x) begin
          t = vx[1]; vx[1] = split_x; split_x = t;
        end
        top_half = 1'b0;
      end
      row = vy[0];
      start_row();
      drawing = 1'b1;
      return p;
    end
    if (!drawing) return p;
    p.x = span_x[W-1:0];
    p.y = row[W-1:0];
    p.c = tri_color;
    p.v = 1'b1;
    if (span_x != span_end) begin
      span_x += (span_x < span_end) ? 1 : -1;
    end else if (!top_half) begin
      if (row < vy[1]) begin
        row++; start_row();
      end else if (vy[1] < vy[2]) begin
        top_half = 1'b1; row = vy[1]; start_row();
      end else begin
        drawing = 1'b0;
      end
    end else if (row < vy[2]) begin
      row++; start_row();
    end else begin
      drawing = 1'b0;
    end
    p.l = !drawing;
    return p;
  endfunction

  // Send one item; the expectation is queued on the edge that takes it.
  task automatic send_item(bit m, int x0 = 0, int y0 = 0, int x1 = 0, int y1 = 0,
                           int x2 = 0, int y2 = 0, logic [23:0] col = '0);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_valid = 1'b1;
    mode = m;
    ax = W'(x0); ay = W'(y0); bx = W'(x1); by_coord = W'(y1); cx = W'(x2); cy = W'(y2);
    fill_color = col;
    do @(posedge clk); while (in_stall);
    pending_pixels.push_back(raster_next(m, x0, y0, x1, y1, x2, y2, col));
    @(negedge clk);
    in_valid = 1'b0;
    mode = 1'($urandom_range(1));
    ax = W'($urandom); ay = W'($urandom); fill_color = 24'($urandom);
  endtask

  // Load a triangle, then step up to max_steps pixels or until it completes.
  task automatic draw_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                          logic [23:0] col, int max_steps);
    int n;
    send_item(tsf_pkg::MODE_LOAD, x0, y0, x1, y1, x2, y2, col);
    n = 0;
    while (drawing && n < max_steps) begin
      send_item(tsf_pkg::MODE_STEP);
      n++;
    end
  endtask

  // Receiver stalls at random, changed on the falling edge.
  always @(negedge clk) out_stall <= !rst && ($urandom_range(99) < stall_pct);

  // Compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    pixel_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected item x=%0d y=%0d", $time, pixel_x, pixel_y);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (pixel_x !== e.x || pixel_y !== e.y || pixel_color !== e.c ||
            pixel_valid !== e.v || last_pixel !== e.l) begin
          $display("%0t: mismatch exp x=%0d y=%0d c=%h v=%b l=%b", $time,
                   $signed(e.x), $signed(e.y), e.c, e.v, e.l);
          $display("%0t:          got x=%0d y=%0d c=%h v=%b l=%b", $time,
                   pixel_x, pixel_y, pixel_color, pixel_valid, last_pixel);
          errors++;
        end
      end
    end
  end

  // Idle steps, flat triangle, and a finished triangle going idle.
  task automatic test_idle_and_flat();
    send_item(tsf_pkg::MODE_STEP);
    draw_tri(5, 7, -3, 7, 100, 7, 24'hABCDEF, 4);
    send_item(tsf_pkg::MODE_STEP);
    draw_tri(0, 0, 2, 2, -1, 3, 24'h123456, 100);
    send_item(tsf_pkg::MODE_STEP);
  endtask

  // Flat-top only, flat-bottom only, swapped middle, spans walking left.
  task automatic test_shapes();
    draw_tri(4, 10, -2, 10, 1, 13, 24'hFF0000, 200);
    draw_tri(0, -5, 3, -8, -4, -5, 24'h00FF00, 200);
    draw_tri(0, 0, 6, 3, 1, 6, 24'h0000FF, 200);
    draw_tri(3, 0, -3, 3, 6, 5, 24'hFFFFFF, 200);
  endtask

  // Coordinate extremes; a load before a triangle completes abandons it.
  task automatic test_extremes();
    draw_tri(-2048, -2048, 2047, -2048, 0, -2047, 24'h000000, 3);
    draw_tri(2047, 2047, -2048, 2046, 2047, -2048, 24'hFFFFFF, 4);
    draw_tri(-2048, 2047, -2048, 2045, -2047, 2047, 24'h5A5AA5, 100);
  endtask

  // Mostly small complete triangles; some cut short by a reload, some noise.
  task automatic test_random(int items);
    int bxr, byr, r, k, sent;
    int xs[3], ys[3];
    sent = 0;
    while (sent < items) begin
      k = $urandom_range(99);
      if (k < 5) begin
        send_item(tsf_pkg::MODE_STEP);
        sent++;
      end else begin
        r = ($urandom_range(9) == 0) ? 12 : $urandom_range(5);
        bxr = $urandom_range(4095 - 40) - 2048 + 20;
        byr = $urandom_range(4095 - 40) - 2048 + 20;
        for (int i = 0; i < 3; i++) begin
          xs[i] = bxr + $urandom_range(2 * r) - r;
          ys[i] = byr + $urandom_range(2 * r) - r;
        end
        if ($urandom_range(19) == 0) ys[1] = ys[0];
        if ($urandom_range(19) == 0) ys[2] = ys[1];
        draw_tri(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], 24'($urandom),
                 (k < 80) ? 400 : $urandom_range(12));
        sent += 1 + (k < 80 ? 20 : 6);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_idle_and_flat();
    test_shapes();
    test_extremes();
    idle_pct = 0;  stall_pct = 0;  test_random(200);
    idle_pct = 86; stall_pct = 0;  test_random(200);
    idle_pct = 0;  stall_pct = 86; test_random(200);
    idle_pct = 37; stall_pct = 37; test_random(200);
    wait (pending_pixels.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("tb failed");
    $finish;
  end

endmodule
